// ===== hw/rtl/docr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Digit occurrence counter package
// Shared payload types and the sequencer state type.
// ---------------------------------------------------------------------------
package docr_pkg;

  localparam int FIELD_W = 40;

  typedef struct packed {
    logic [FIELD_W-1:0] low_bound;
    logic [FIELD_W-1:0] high_bound;
    logic [3:0]         target_digit;
    logic [3:0]         target_count;
  } docr_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] match_total;
    logic               empty_range;
  } docr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CONV,
    ST_ENT_RD,
    ST_ENT,
    ST_DIG_RD,
    ST_DIG_WR,
    ST_FIN_RD,
    ST_FIN_ACC,
    ST_DONE
  } docr_state_t;

endpackage

// ===== hw/rtl/docr_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module docr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/digit_occurrence_range_counter_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Digit occurrence range counter
// Counts integers in a closed range holding a digit an exact number of times.
// ---------------------------------------------------------------------------
// Usage: drive in_data and raise start while busy is low; the query is taken
// at that edge and busy rises. Exactly one result beat appears on out_data
// with out_valid high for a single cycle, after which busy falls. The
// receiver cannot stall, so the beat must be taken when it is shown.
// An empty range shows its beat in the cycle after it is taken. Otherwise the
// block runs the digit programme for the high bound and, when the low bound
// is non-zero, again for the low bound minus one. A pass clears both table
// RAMs, converts the bound to decimal by shift-and-add-3, then for each
// position reads every (count, started, tight) entry of the source table
// and, for a non-zero entry, adds it into the destination table with one
// read and one write per allowed digit. The two tables swap roles at each
// position. A new query is taken only after the result beat.
// Reset returns the sequencer to idle; the tables are cleared at the start
// of every pass, so no clearing pass follows reset.
// ---------------------------------------------------------------------------
module digit_occurrence_range_counter_unit
  import docr_pkg::*;
#(
  parameter int MAX_DIGITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  docr_in_t  in_data,
  output logic      out_valid,
  output docr_out_t out_data
);

  function automatic logic [63:0] cap_of(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v - 64'd1;
  endfunction

  localparam int NENT = 4 * (MAX_DIGITS + 1);
  localparam int AW   = $clog2(NENT);
  localparam int PW   = $clog2(MAX_DIGITS + 1);
  localparam int CW   = $clog2(MAX_DIGITS + 2);
  localparam int BW   = $clog2(FIELD_W);
  localparam int DW   = 4 * MAX_DIGITS;
  localparam logic [63:0] CAP = cap_of(MAX_DIGITS);

  docr_state_t state_r, state_nxt;

  logic [FIELD_W-1:0] lo_r, lo_nxt;
  logic [3:0]         d_r, d_nxt, k_r, k_nxt;
  logic [FIELD_W-1:0] x_r, x_nxt;
  logic [DW-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic [BW-1:0]      b_r, b_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [AW-1:0]      e_r, e_nxt;
  logic [3:0]         g_r, g_nxt;
  logic [FIELD_W-1:0] w_r, w_nxt;
  logic [FIELD_W-1:0] tot_r, tot_nxt, pass_r, pass_nxt;
  logic               second_r, second_nxt;
  logic               empty_r, empty_nxt;
  logic               bank_r, bank_nxt;

  logic               t0_we, t1_we;
  logic [AW-1:0]      t0_wa, t0_ra, t1_wa, t1_ra;
  logic [FIELD_W-1:0] t0_wd, t1_wd, t0_rd, t1_rd;
  logic [FIELD_W-1:0] src_rd, dst_rd;

  docr_ram #(.WIDTH(FIELD_W), .DEPTH(NENT)) u_tab0 (
    .clk(clk), .we(t0_we), .waddr(t0_wa), .wdata(t0_wd),
    .raddr(t0_ra), .rdata(t0_rd)
  );

  docr_ram #(.WIDTH(FIELD_W), .DEPTH(NENT)) u_tab1 (
    .clk(clk), .we(t1_we), .waddr(t1_wa), .wdata(t1_wd),
    .raddr(t1_ra), .rdata(t1_rd)
  );

  assign src_rd = bank_r ? t1_rd : t0_rd;
  assign dst_rd = bank_r ? t0_rd : t1_rd;

  // Entry address is {count, started, tight}.
  logic [CW-1:0] e_c;
  logic          e_s, e_t;
  logic [3:0]    lim, dsel;
  logic          ns, nt, hit, ok;
  logic [CW-1:0] nc;
  logic [AW-1:0] tgt, fin_ra;
  logic [FIELD_W-1:0] fin_add, pass_sum;
  logic          zero_hit, last_e, last_p, last_g, last_b, ent_zero, adv_e;

  always_comb begin
    e_c      = CW'(e_r >> 2);
    e_s      = e_r[1];
    e_t      = e_r[0];
    dsel     = bcd_r[4*int'(p_r) +: 4];
    lim      = e_t ? dsel : 4'd9;
    ns       = e_s || (g_r != 4'd0);
    hit      = ns && (g_r == d_r);
    nc       = e_c + CW'(hit);
    nt       = e_t && (g_r == lim);
    ok       = (int'(nc) <= int'(k_r)) && (int'(nc) <= MAX_DIGITS);
    tgt      = AW'({nc, ns, nt});
    fin_ra   = (int'(k_r) <= MAX_DIGITS) ? AW'({CW'(k_r), 1'b1, e_r[0]}) : '0;
    fin_add  = (int'(k_r) <= MAX_DIGITS) ? src_rd : '0;
    zero_hit = (k_r == ((d_r == 4'd0) ? 4'd1 : 4'd0));
    pass_sum = pass_r + fin_add + ((e_r[0] && zero_hit) ? FIELD_W'(1) : '0);
    last_e   = (e_r == AW'(NENT - 1));
    last_p   = (p_r == '0);
    last_g   = (g_r == lim);
    last_b   = (b_r == BW'(FIELD_W - 1));
    ent_zero = (src_rd == '0);
    adv_e    = ((state_r == ST_ENT) && ent_zero) || ((state_r == ST_DIG_WR) && last_g);
    bcd_adj  = bcd_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_adj[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_adj[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r     <= lo_nxt;
    d_r      <= d_nxt;
    k_r      <= k_nxt;
    x_r      <= x_nxt;
    bcd_r    <= bcd_nxt;
    b_r      <= b_nxt;
    p_r      <= p_nxt;
    e_r      <= e_nxt;
    g_r      <= g_nxt;
    w_r      <= w_nxt;
    tot_r    <= tot_nxt;
    pass_r   <= pass_nxt;
    second_r <= second_nxt;
    empty_r  <= empty_nxt;
    bank_r   <= bank_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.low_bound > in_data.high_bound) ? ST_DONE : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (last_e) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (last_b) begin
          state_nxt = ST_ENT_RD;
        end
      end
      ST_ENT_RD: begin
        state_nxt = ST_ENT;
      end
      ST_ENT: begin
        if (!ent_zero) begin
          state_nxt = ST_DIG_RD;
        end else if (last_e && last_p) begin
          state_nxt = ST_FIN_RD;
        end else begin
          state_nxt = ST_ENT_RD;
        end
      end
      ST_DIG_RD: begin
        state_nxt = ST_DIG_WR;
      end
      ST_DIG_WR: begin
        if (!last_g) begin
          state_nxt = ST_DIG_RD;
        end else if (last_e && last_p) begin
          state_nxt = ST_FIN_RD;
        end else begin
          state_nxt = ST_ENT_RD;
        end
      end
      ST_FIN_RD: begin
        state_nxt = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        if (!e_r[0]) begin
          state_nxt = ST_FIN_RD;
        end else if (second_r || lo_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt = lo_r; d_nxt = d_r; k_nxt = k_r; x_nxt = x_r; bcd_nxt = bcd_r;
    b_nxt = b_r; p_nxt = p_r; e_nxt = e_r; g_nxt = g_r; w_nxt = w_r;
    tot_nxt = tot_r; pass_nxt = pass_r; second_nxt = second_r;
    empty_nxt = empty_r; bank_nxt = bank_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          d_nxt = in_data.target_digit;
          k_nxt = in_data.target_count;
          empty_nxt = in_data.low_bound > in_data.high_bound;
          lo_nxt = (64'(in_data.low_bound) > CAP) ? CAP[FIELD_W-1:0] : in_data.low_bound;
          x_nxt = (64'(in_data.high_bound) > CAP) ? CAP[FIELD_W-1:0] : in_data.high_bound;
          bcd_nxt = '0;
          b_nxt = '0;
          e_nxt = '0;
          bank_nxt = 1'b0;
          tot_nxt = '0;
          second_nxt = 1'b0;
        end
      end
      ST_CLEAR: begin
        e_nxt = last_e ? '0 : e_r + AW'(1);
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[DW-2:0], x_r[FIELD_W-1]};
        x_nxt = {x_r[FIELD_W-2:0], 1'b0};
        b_nxt = b_r + BW'(1);
        if (last_b) begin
          p_nxt = PW'(MAX_DIGITS - 1);
          e_nxt = '0;
        end
      end
      ST_ENT: begin
        w_nxt = src_rd;
        g_nxt = 4'd0;
      end
      ST_DIG_WR: begin
        if (!last_g) begin
          g_nxt = g_r + 4'd1;
        end
      end
      ST_FIN_ACC: begin
        pass_nxt = pass_sum;
        if (!e_r[0]) begin
          e_nxt = AW'(1);
        end else if (!second_r) begin
          tot_nxt = pass_sum;
          if (lo_r != '0) begin
            second_nxt = 1'b1;
            x_nxt = lo_r - FIELD_W'(1);
            bcd_nxt = '0;
            b_nxt = '0;
            e_nxt = '0;
            bank_nxt = 1'b0;
          end
        end else begin
          tot_nxt = tot_r - pass_sum;
        end
      end
      default: begin
      end
    endcase
    if (adv_e) begin
      if (last_e) begin
        e_nxt = '0;
        bank_nxt = !bank_r;
        if (last_p) begin
          pass_nxt = '0;
        end else begin
          p_nxt = p_r - PW'(1);
        end
      end else begin
        e_nxt = e_r + AW'(1);
      end
    end
  end

  always_comb begin
    t0_we = 1'b0; t0_wa = e_r; t0_wd = '0; t0_ra = e_r;
    t1_we = 1'b0; t1_wa = e_r; t1_wd = '0; t1_ra = e_r;
    case (state_r)
      ST_CLEAR: begin
        t0_we = 1'b1;
        t0_wd = (e_r == AW'(1)) ? FIELD_W'(1) : '0;
        t1_we = 1'b1;
      end
      ST_ENT: begin
        if (bank_r) begin
          t1_we = 1'b1;
        end else begin
          t0_we = 1'b1;
        end
      end
      ST_DIG_RD: begin
        if (bank_r) begin
          t0_ra = ok ? tgt : '0;
        end else begin
          t1_ra = ok ? tgt : '0;
        end
      end
      ST_DIG_WR: begin
        if (bank_r) begin
          t0_we = ok;
          t0_wa = tgt;
          t0_wd = dst_rd + w_r;
        end else begin
          t1_we = ok;
          t1_wa = tgt;
          t1_wd = dst_rd + w_r;
        end
      end
      ST_FIN_RD: begin
        if (bank_r) begin
          t1_ra = fin_ra;
        end else begin
          t0_ra = fin_ra;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    out_data.match_total = empty_r ? '0 : tot_r;
    out_data.empty_range = empty_r;
  end

endmodule

// ===== hw/rtl/docr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Digit occurrence counter checker
// Port-level checks on the command and result channels.
// ---------------------------------------------------------------------------
module docr_checker
  import docr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input docr_out_t out_data
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("no busy after start");

  a_valid_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a query");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.empty_range) |-> (out_data.match_total == '0))
    else $error("empty range with non-zero total");

endmodule

bind digit_occurrence_range_counter_unit docr_checker u_docr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
